/* sv/rdbe_pkg.sv */
package rdbe_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;

	localparam logic [CFG_INDEX_W-1:0] CFG_REFL_RED   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REFL_GREEN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REFL_BLUE  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_COEFF_A    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_COEFF_B    = 3'd4;

	localparam logic [16:0] COEFF_A_RESET = 17'h10000;
	localparam logic [22:0] INV_PI_Q24    = 23'd5340354;
	localparam logic [15:0] VALUE_MAX     = 16'hFFFF;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
		logic signed [15:0] in_z;
	} dir_pair_t;

	typedef struct packed {
		logic [15:0] value_red;
		logic [15:0] value_green;
		logic [15:0] value_blue;
		logic        clipped;
	} result_t;

endpackage

/* sv/rough_diffuse_brdf_eval.sv */
// Oren-Nayar rough diffuse evaluator. Each word on the pair channel is an outgoing and an
// incident unit direction in the shading frame; each word on the brdf channel is the
// per-channel reflectance refl/pi * (A + B * max(0, cos(phi_i - phi_o)) * sin(alpha) *
// tan(beta)) in unsigned fixed point, plus a flag that tells when tan beta or a channel
// saturated. The block takes one word per clock while it is not stalled; each result passes
// first through the bit-per-cycle square roots of sin theta, then through the bit-per-cycle
// dividers that form cos phi, sin phi and tan beta, and last through the multiply chain. The
// whole pipeline stalls while the skid word is full; the skid word takes the last stage's result
// when the output is not taken. The user must write registers through the cfg port only while
// no words are in flight; the block itself does not enforce this.
module rough_diffuse_brdf_eval #(
	parameter int DIR_FRAC_BITS = 15,
	parameter int OUT_FRAC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pair_valid,
	output logic                              pair_ready,
	input  rdbe_pkg::dir_pair_t               pair,
	output logic                              brdf_valid,
	input  logic                              brdf_ready,
	output rdbe_pkg::result_t                 brdf,
	input  logic                              cfg_we,
	input  logic [rdbe_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rdbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW  = 46 - DIR_FRAC_BITS;
	localparam int AXW = (AW > 31) ? AW : 31;
	localparam int TW  = (30 + OUT_FRAC_BITS > 62 - DIR_FRAC_BITS) ?
		30 + OUT_FRAC_BITS : 62 - DIR_FRAC_BITS;
	localparam int T2W = 48 - OUT_FRAC_BITS;
	localparam int SW  = ((48 - OUT_FRAC_BITS > 31) ? 48 - OUT_FRAC_BITS : 31) + 1;
	localparam int VW  = SW + OUT_FRAC_BITS - 31;

	function automatic logic [15:0] mag16(input logic [15:0] v);
		mag16 = v[15] ? 16'(~v + 16'd1) : v;
	endfunction

	// Configuration registers.
	logic [15:0] refl_q [0:2];
	logic [16:0] coeff_a_q;
	logic [15:0] coeff_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refl_q[0] <= '0;
			refl_q[1] <= '0;
			refl_q[2] <= '0;
			coeff_a_q <= rdbe_pkg::COEFF_A_RESET;
			coeff_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rdbe_pkg::CFG_REFL_RED:   refl_q[0] <= cfg_data[15:0];
				rdbe_pkg::CFG_REFL_GREEN: refl_q[1] <= cfg_data[15:0];
				rdbe_pkg::CFG_REFL_BLUE:  refl_q[2] <= cfg_data[15:0];
				rdbe_pkg::CFG_COEFF_A:    coeff_a_q <= cfg_data;
				rdbe_pkg::CFG_COEFF_B:    coeff_b_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic skid_vld_q;
	rdbe_pkg::result_t skid_q;

	assign adv = ~skid_vld_q;
	assign pair_ready = adv;

	// Valid bits, one per pipeline register.
	logic vld_s1 [0:30];
	logic vld_s2 [0:30];
	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= 30; j++) begin
				vld_s1[j] <= 1'b0;
				vld_s2[j] <= 1'b0;
			end
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s1[0] <= pair_valid;
			for (int j = 0; j < 30; j++) begin
				vld_s1[j+1] <= vld_s1[j];
				vld_s2[j+1] <= vld_s2[j];
			end
			vld_s2[0] <= vld_s1[30];
			vld_s3  <= vld_s2[30];
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// Square root section: index 0 captures the input, each later index settles one root bit.
	logic [59:0]        val_s1  [0:30][0:1];
	logic [33:0]        rem_s1  [0:29][0:1];
	logic [29:0]        root_s1 [0:30][0:1];
	logic               unit_s1 [0:30][0:1];
	logic signed [15:0] cx_s1   [0:30][0:1];
	logic signed [15:0] cy_s1   [0:30][0:1];
	logic [15:0]        cz_s1   [0:30][0:1];

	logic signed [15:0] in_comp [0:1][0:2];
	assign in_comp[0][0] = pair.out_x;
	assign in_comp[0][1] = pair.out_y;
	assign in_comp[0][2] = pair.out_z;
	assign in_comp[1][0] = pair.in_x;
	assign in_comp[1][1] = pair.in_y;
	assign in_comp[1][2] = pair.in_z;

	for (genvar d = 0; d < 2; d++) begin : g_load
		logic signed [31:0] zz_w;
		logic [60:0] one_w, zz61_w, s2_w;
		logic [59:0] sq_w;

		assign zz_w   = in_comp[d][2] * in_comp[d][2];
		assign one_w  = 61'(1) << (2 * DIR_FRAC_BITS);
		assign zz61_w = 61'($unsigned(zz_w));
		assign s2_w   = (zz61_w >= one_w) ? '0 : one_w - zz61_w;
		assign sq_w   = 60'(s2_w << (60 - 2 * DIR_FRAC_BITS));

		// With z at zero, sin theta is exactly one, which the 30-bit root cannot hold;
		// that case travels as its own bit and the root runs on zero.
		always_ff @(posedge clk) begin
			if (adv) begin
				val_s1[0][d]  <= sq_w;
				rem_s1[0][d]  <= '0;
				root_s1[0][d] <= '0;
				unit_s1[0][d] <= (s2_w == one_w);
				cx_s1[0][d]   <= in_comp[d][0];
				cy_s1[0][d]   <= in_comp[d][1];
				cz_s1[0][d]   <= mag16(in_comp[d][2]);
			end
		end
	end

	for (genvar j = 0; j < 30; j++) begin : g_root
		for (genvar d = 0; d < 2; d++) begin : g_dir
			logic [33:0] r_w, t_w;
			logic ge_w;

			assign r_w  = {rem_s1[j][d][31:0], val_s1[j][d][2*(29-j)+1 -: 2]};
			assign t_w  = {2'b00, root_s1[j][d], 2'b01};
			assign ge_w = (r_w >= t_w);

			always_ff @(posedge clk) begin
				if (adv) begin
					val_s1[j+1][d]  <= val_s1[j][d];
					root_s1[j+1][d] <= {root_s1[j][d][28:0], ge_w};
					unit_s1[j+1][d] <= unit_s1[j][d];
					cx_s1[j+1][d]   <= cx_s1[j][d];
					cy_s1[j+1][d]   <= cy_s1[j][d];
					cz_s1[j+1][d]   <= cz_s1[j][d];
				end
			end

			if (j < 29) begin : g_rem
				always_ff @(posedge clk) begin
					if (adv) begin
						rem_s1[j+1][d] <= ge_w ? r_w - t_w : r_w;
					end
				end
			end
		end
	end

	logic [30:0] sin_w [0:1];

	for (genvar d = 0; d < 2; d++) begin : g_sin
		assign sin_w[d] = {unit_s1[30][d], root_s1[30][d]};
	end

	// Divider section: cos phi and sin phi for both directions, and tan beta.
	// Index c is 0 for the x (cos) ratio and 1 for the y (sin) ratio.
	logic [29:0] pr_s2 [0:29][0:1][0:1];
	logic [29:0] pq_s2 [0:30][0:1][0:1];
	logic        ps_s2 [0:30][0:1][0:1];
	logic        pn_s2 [0:30][0:1][0:1];
	logic [30:0] dv_s2 [0:29][0:1];
	logic        pz_s2 [0:30][0:1];
	logic [30:0] sa_s2 [0:30];
	logic [15:0] tden_s2 [0:15];
	logic [TW-1:0] tr_s2 [0:15];
	logic [15:0] tq_s2 [0:30];
	logic        tclip_s2 [0:30];

	for (genvar d = 0; d < 2; d++) begin : g_dsetup
		logic [AXW-1:0] ax_w, ay_w;

		assign ax_w  = AXW'(mag16(cx_s1[30][d])) << (30 - DIR_FRAC_BITS);
		assign ay_w  = AXW'(mag16(cy_s1[30][d])) << (30 - DIR_FRAC_BITS);

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s2[0][d]       <= sin_w[d];
				pz_s2[0][d]       <= (sin_w[d] == '0);
				ps_s2[0][d][0]    <= (ax_w >= AXW'(sin_w[d]));
				ps_s2[0][d][1]    <= (ay_w >= AXW'(sin_w[d]));
				pn_s2[0][d][0]    <= cx_s1[30][d][15];
				pn_s2[0][d][1]    <= cy_s1[30][d][15];
				pr_s2[0][d][0]    <= ax_w[29:0];
				pr_s2[0][d][1]    <= ay_w[29:0];
				pq_s2[0][d][0]    <= '0;
				pq_s2[0][d][1]    <= '0;
			end
		end
	end

	// The steeper direction gives tan beta, the other one sin alpha.
	logic          tsel_w;
	logic [15:0]   tden_w;
	logic [TW-1:0] tnum_w, tlim_w;

	assign tsel_w = cz_s1[30][1] > cz_s1[30][0];
	assign tden_w = tsel_w ? cz_s1[30][1] : cz_s1[30][0];
	assign tnum_w = TW'(tsel_w ? sin_w[1] : sin_w[0]) << OUT_FRAC_BITS;
	assign tlim_w = TW'(tden_w) << (30 - DIR_FRAC_BITS + 16);

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s2[0]    <= tsel_w ? sin_w[0] : sin_w[1];
			tden_s2[0]  <= tden_w;
			tr_s2[0]    <= tnum_w;
			tq_s2[0]    <= '0;
			tclip_s2[0] <= (tden_w == '0) || (tnum_w >= tlim_w);
		end
	end

	for (genvar j = 0; j < 30; j++) begin : g_div
		for (genvar d = 0; d < 2; d++) begin : g_dir
			for (genvar c = 0; c < 2; c++) begin : g_cs
				logic [30:0] r_w;
				logic ge_w;

				assign r_w  = {pr_s2[j][d][c], 1'b0};
				assign ge_w = (r_w >= dv_s2[j][d]);

				always_ff @(posedge clk) begin
					if (adv) begin
						pq_s2[j+1][d][c] <= {pq_s2[j][d][c][28:0], ge_w};
						ps_s2[j+1][d][c] <= ps_s2[j][d][c];
						pn_s2[j+1][d][c] <= pn_s2[j][d][c];
					end
				end

				if (j < 29) begin : g_rem
					always_ff @(posedge clk) begin
						if (adv) begin
							pr_s2[j+1][d][c] <= ge_w ? 30'(r_w - dv_s2[j][d])
								: r_w[29:0];
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					pz_s2[j+1][d] <= pz_s2[j][d];
				end
			end

			if (j < 29) begin : g_dv
				always_ff @(posedge clk) begin
					if (adv) begin
						dv_s2[j+1][d] <= dv_s2[j][d];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sa_s2[j+1]    <= sa_s2[j];
				tclip_s2[j+1] <= tclip_s2[j];
			end
		end

		if (j < 16) begin : g_tan
			logic [TW-1:0] sub_w;
			logic ge_w;

			assign sub_w = TW'(tden_s2[j]) << (30 - DIR_FRAC_BITS + 15 - j);
			assign ge_w  = (tr_s2[j] >= sub_w);

			always_ff @(posedge clk) begin
				if (adv) begin
					tq_s2[j+1] <= tq_s2[j] | (16'(ge_w) << (15 - j));
				end
			end

			if (j < 15) begin : g_rem
				always_ff @(posedge clk) begin
					if (adv) begin
						tr_s2[j+1]   <= ge_w ? tr_s2[j] - sub_w : tr_s2[j];
						tden_s2[j+1] <= tden_s2[j];
					end
				end
			end
		end else begin : g_tpass
			always_ff @(posedge clk) begin
				if (adv) begin
					tq_s2[j+1] <= tq_s2[j];
				end
			end
		end
	end

	// Finish the ratios: clamped, signed, Q.30.
	logic signed [31:0] cs_s3 [0:1][0:1];
	logic [30:0] sa_s3;
	logic [15:0] tan_s3;
	logic        clip_s3;

	for (genvar d = 0; d < 2; d++) begin : g_fin
		for (genvar c = 0; c < 2; c++) begin : g_cs
			logic [31:0] m_w;

			always_comb begin
				if (pz_s2[30][d]) begin
					m_w = (c == 0) ? 32'h4000_0000 : 32'h0;
				end else if (ps_s2[30][d][c]) begin
					m_w = 32'h4000_0000;
				end else begin
					m_w = {2'b00, pq_s2[30][d][c]};
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					cs_s3[d][c] <= (pn_s2[30][d][c] && !pz_s2[30][d]) ?
						-$signed(m_w) : $signed(m_w);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s3   <= sa_s2[30];
			tan_s3  <= tclip_s2[30] ? rdbe_pkg::VALUE_MAX : tq_s2[30];
			clip_s3 <= tclip_s2[30];
		end
	end

	// Multiply chain.
	logic signed [63:0] pcc_s4, pss_s4;
	logic [30:0] sa_s4, sa_s5;
	logic [15:0] tan_s4, tan_s5, tan_s6;
	logic        clip_s4, clip_s5, clip_s6, clip_s7, clip_s8, clip_s9, clip_s10, clip_s11;
	logic [31:0] maxc_s5;
	logic [61:0] m1_s6;
	logic [47:0] t2p_s7;
	logic [T2W+15:0] t3p_s8;
	logic [SW-1:0] sum_s9;
	logic [SW+15:0] prod_s10 [0:2];
	logic [SW+16:0] scl_s11 [0:2];
	rdbe_pkg::result_t res_s12;

	logic signed [63:0] c_w;
	assign c_w = pcc_s4 + pss_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pcc_s4  <= cs_s3[0][0] * cs_s3[1][0];
			pss_s4  <= cs_s3[0][1] * cs_s3[1][1];
			sa_s4   <= sa_s3;
			tan_s4  <= tan_s3;
			clip_s4 <= clip_s3;

			maxc_s5 <= (!c_w[63] && c_w != '0) ? c_w[61:30] : '0;
			sa_s5   <= sa_s4;
			tan_s5  <= tan_s4;
			clip_s5 <= clip_s4;

			m1_s6   <= 62'(maxc_s5 * sa_s5);
			tan_s6  <= tan_s5;
			clip_s6 <= clip_s5;

			t2p_s7  <= 48'(m1_s6[61:30] * tan_s6);
			clip_s7 <= clip_s6;

			t3p_s8  <= (T2W+16)'(t2p_s7[47:OUT_FRAC_BITS] * coeff_b_q);
			clip_s8 <= clip_s7;

			sum_s9  <= SW'({coeff_a_q, 14'b0}) + SW'(t3p_s8[T2W+15:16]);
			clip_s9 <= clip_s8;

			for (int ch = 0; ch < 3; ch++) begin
				prod_s10[ch] <= (SW+16)'(sum_s9 * refl_q[ch]);
				scl_s11[ch]  <= (SW+17)'(prod_s10[ch][SW+15:22] * rdbe_pkg::INV_PI_Q24);
			end
			clip_s10 <= clip_s9;
			clip_s11 <= clip_s10;
		end
	end

	logic [VW-1:0] chv_w [0:2];
	logic          chsat_w [0:2];
	logic [15:0]   chout_w [0:2];

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		assign chv_w[ch]   = scl_s11[ch][SW+16:48-OUT_FRAC_BITS];
		assign chsat_w[ch] = (chv_w[ch] > VW'(rdbe_pkg::VALUE_MAX));
		assign chout_w[ch] = chsat_w[ch] ? rdbe_pkg::VALUE_MAX : chv_w[ch][15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s12.value_red   <= chout_w[0];
			res_s12.value_green <= chout_w[1];
			res_s12.value_blue  <= chout_w[2];
			res_s12.clipped     <= clip_s11 | chsat_w[0] | chsat_w[1] | chsat_w[2];
		end
	end

	// Skid word: holds the last stage's result when it moves on while the output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (brdf_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s12 && !brdf_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_s12 && !brdf_ready) begin
			skid_q <= res_s12;
		end
	end

	assign brdf_valid = skid_vld_q | vld_s12;
	assign brdf       = skid_vld_q ? skid_q : res_s12;

`ifndef SYNTHESIS
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1[30] |->
			(64'(root_s1[30][0]) * 64'(root_s1[30][0]) <= 64'(val_s1[30][0])) &&
			((64'(root_s1[30][0]) + 64'd1) * (64'(root_s1[30][0]) + 64'd1) >
				64'(val_s1[30][0])))
		else $error("square root result out of range");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(res_s12) && $stable(vld_s12))
		else $error("last stage moved while the skid word was full");

	a_skid_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s12 && !brdf_ready && !skid_vld_q) |=>
			(skid_vld_q && skid_q == $past(res_s12)))
		else $error("stalled word not kept in the skid register");

	a_cos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (maxc_s5 <= 32'h8000_0000))
		else $error("cosine term exceeds its bound");
`endif

endmodule

/* tb/sv/rough_diffuse_brdf_eval_tb.sv */
module rough_diffuse_brdf_eval_tb;

	localparam int DIR_FB   = 15;
	localparam int OUT_FB   = 12;
	localparam int LATENCY  = 72;
	localparam int WATCHDOG = 20000;

	class brdf_scoreboard;
		rdbe_pkg::result_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_pair(rdbe_pkg::result_t r);
			pending.push_back(r);
		endfunction

		function void check_brdf(rdbe_pkg::result_t got);
			rdbe_pkg::result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word, got %h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.value_red !== want.value_red) begin
				$display("%0t: red expected %h actual %h", $realtime, want.value_red,
					got.value_red);
				errors++;
			end
			if (got.value_green !== want.value_green) begin
				$display("%0t: green expected %h actual %h", $realtime, want.value_green,
					got.value_green);
				errors++;
			end
			if (got.value_blue !== want.value_blue) begin
				$display("%0t: blue expected %h actual %h", $realtime, want.value_blue,
					got.value_blue);
				errors++;
			end
			if (got.clipped !== want.clipped) begin
				$display("%0t: clipped expected %b actual %b", $realtime, want.clipped,
					got.clipped);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pair_valid = 1'b0;
	logic pair_ready;
	rdbe_pkg::dir_pair_t pair = '0;
	logic brdf_valid;
	logic brdf_ready = 1'b0;
	rdbe_pkg::result_t brdf;
	logic cfg_we = 1'b0;
	logic [rdbe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [rdbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [15:0] m_red, m_green, m_blue, m_b;
	logic [16:0] m_a;
	brdf_scoreboard sb;
	int idle_cycles = 0;
	bit hold_rx = 0;
	bit stim_done = 0;

	rough_diffuse_brdf_eval #(.DIR_FRAC_BITS(DIR_FB), .OUT_FRAC_BITS(OUT_FB)) u_top (
		.clk(clk), .arst_n(arst_n), .pair_valid(pair_valid), .pair_ready(pair_ready),
		.pair(pair), .brdf_valid(brdf_valid), .brdf_ready(brdf_ready), .brdf(brdf),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Component over sin theta, clamped to one, in Q.30.
	function automatic longint ratio_q30(longint comp, longint unsigned st, longint dflt);
		longint unsigned a, m;
		if (st == 0) return dflt;
		a = (comp < 0 ? -comp : comp) << (30 - DIR_FB);
		m = (a >= st) ? (64'd1 << 30) : (a << 30) / st;
		return comp < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned sin_q30(longint z);
		longint unsigned zz, one, s2;
		zz = z * z;
		one = 64'd1 << (2 * DIR_FB);
		s2 = (zz >= one) ? 0 : one - zz;
		return int_sqrt(s2 << (60 - 2 * DIR_FB));
	endfunction

	function automatic logic [15:0] scale_channel(longint unsigned sum,
			logic [15:0] refl, ref bit clip);
		longint unsigned p;
		p = ((sum * refl) >> 22) * 64'd5340354;
		p >>= (48 - OUT_FB);
		if (p > 16'hFFFF) begin
			clip = 1;
			p = 16'hFFFF;
		end
		return p[15:0];
	endfunction

	function automatic rdbe_pkg::result_t oren_nayar(rdbe_pkg::dir_pair_t d);
		rdbe_pkg::result_t r;
		longint ox, oy, oz, ix, iy, iz, ocp, osp, icp, isp, c;
		longint unsigned ost, ist, oca, ica, mc, sa, num, den, tb, t, sum;
		bit clip;
		ox = d.out_x; oy = d.out_y; oz = d.out_z;
		ix = d.in_x; iy = d.in_y; iz = d.in_z;
		clip = 0;
		ost = sin_q30(oz);
		ist = sin_q30(iz);
		oca = oz < 0 ? -oz : oz;
		ica = iz < 0 ? -iz : iz;
		ocp = ratio_q30(ox, ost, 64'sd1 << 30);
		osp = ratio_q30(oy, ost, 0);
		icp = ratio_q30(ix, ist, 64'sd1 << 30);
		isp = ratio_q30(iy, ist, 0);
		c = icp * ocp + isp * osp;
		mc = c > 0 ? (longint'(c) >>> 30) : 0;
		if (ica > oca) begin
			sa = ost; num = ist; den = ica;
		end else begin
			sa = ist; num = ost; den = oca;
		end
		if (den == 0) begin
			tb = 16'hFFFF;
			clip = 1;
		end else begin
			tb = (num << OUT_FB) / (den << (30 - DIR_FB));
			if (tb > 16'hFFFF) begin
				tb = 16'hFFFF;
				clip = 1;
			end
		end
		t = (mc * sa) >> 30;
		t = (t * tb) >> OUT_FB;
		t = (t * m_b) >> 16;
		sum = (longint'(m_a) << 14) + t;
		r.value_red = scale_channel(sum, m_red, clip);
		r.value_green = scale_channel(sum, m_green, clip);
		r.value_blue = scale_channel(sum, m_blue, clip);
		r.clipped = clip;
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	// The write enable stays high across back-to-back writes; set_regs drops it.
	task automatic write_reg(logic [rdbe_pkg::CFG_INDEX_W-1:0] idx,
			logic [rdbe_pkg::CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			rdbe_pkg::CFG_REFL_RED:   m_red = v[15:0];
			rdbe_pkg::CFG_REFL_GREEN: m_green = v[15:0];
			rdbe_pkg::CFG_REFL_BLUE:  m_blue = v[15:0];
			rdbe_pkg::CFG_COEFF_A:    m_a = v[16:0];
			rdbe_pkg::CFG_COEFF_B:    m_b = v[15:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [16:0] a, logic [15:0] cb);
		write_reg(rdbe_pkg::CFG_REFL_RED, r);
		write_reg(rdbe_pkg::CFG_REFL_GREEN, g);
		write_reg(rdbe_pkg::CFG_REFL_BLUE, b);
		write_reg(rdbe_pkg::CFG_COEFF_A, a);
		write_reg(rdbe_pkg::CFG_COEFF_B, cb);
		// An unused index must leave everything alone.
		write_reg('1, rdbe_pkg::CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic send_pair(rdbe_pkg::dir_pair_t d, bit no_gap = 0);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g != 0) begin
			pair_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= d;
		@(posedge clk);
		while (!pair_ready) @(posedge clk);
		sb.note_pair(oren_nayar(d));
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic signed [15:0] q15(real v);
		return 16'($rtoi(v * 32768.0));
	endfunction

	function automatic rdbe_pkg::dir_pair_t unit_pair();
		rdbe_pkg::dir_pair_t d;
		real th, ph, s;
		th = $urandom_range(0, 10000) / 10000.0 * 1.5707;
		ph = $urandom_range(0, 10000) / 10000.0 * 6.2831;
		s = $sin(th);
		d.out_x = q15(s * $cos(ph) * 0.9999);
		d.out_y = q15(s * $sin(ph) * 0.9999);
		d.out_z = q15($cos(th) * 0.9999);
		if ($urandom_range(0, 1)) d.out_z = -d.out_z;
		th = $urandom_range(0, 10000) / 10000.0 * 1.5707;
		ph = $urandom_range(0, 10000) / 10000.0 * 6.2831;
		s = $sin(th);
		d.in_x = q15(s * $cos(ph) * 0.9999);
		d.in_y = q15(s * $sin(ph) * 0.9999);
		d.in_z = q15($cos(th) * 0.9999);
		if ($urandom_range(0, 1)) d.in_z = -d.in_z;
		return d;
	endfunction

	function automatic rdbe_pkg::dir_pair_t any_pair();
		rdbe_pkg::dir_pair_t d;
		d = {$urandom, $urandom, $urandom};
		return d;
	endfunction

	task automatic run_random(int n);
		int k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 3) == 0) send_pair(any_pair(), k % 50 > 40);
			else send_pair(unit_pair(), k % 50 > 40);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off requested by the sender side.
	initial begin
		int g, k;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				brdf_ready <= 1'b0;
				for (k = 0; k < 300; k++) @(posedge clk);
				hold_rx = 0;
			end
			g = gap_len();
			if (g != 0) begin
				brdf_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			brdf_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (brdf_valid && brdf_ready) sb.check_brdf(brdf);
		if ((pair_valid && pair_ready) || (brdf_valid && brdf_ready)
				|| (stim_done && sb.pending.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		rdbe_pkg::dir_pair_t d;
		sb = new();
		m_red = 0; m_green = 0; m_blue = 0; m_a = rdbe_pkg::COEFF_A_RESET; m_b = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first, then a rough mid setting for the directed words.
		send_pair(unit_pair());
		drain();
		set_regs(16'h8000, 16'hC000, 16'h4000, 17'h0C000, 16'h6000);
		d = '0; send_pair(d);                                 // both sin theta one
		d = '0; d.out_z = 16'sh7FFF; d.in_z = 16'sh7FFF; send_pair(d);
		d = '0; d.out_z = -16'sh8000; d.in_z = 16'sh4000; d.in_x = 16'sh7FFF;
		send_pair(d);                                         // z^2 at one
		d = '0; d.out_x = 16'sh7FFF; d.in_y = -16'sh8000; send_pair(d);  // zero divisor
		d = '0; d.out_x = 16'sh5A82; d.out_y = 16'sh5A82; d.out_z = 16'sh0010;
		d.in_x = 16'sh5A82; d.in_y = 16'sh5A82; d.in_z = 16'sh0008;
		send_pair(d);                                         // tan overflow
		d = '0; d.out_x = 16'sh7FFF; d.out_z = 16'sh2000; d.in_x = -16'sh7FFF;
		d.in_z = 16'sh3000; send_pair(d);                     // negative cosine
		d = '0; d.out_x = -16'sh8000; d.out_y = -16'sh8000; d.out_z = 16'sh4000;
		d.in_x = 16'sh7FFF; d.in_y = 16'sh7FFF; d.in_z = -16'sh4000;
		send_pair(d);                                         // axis beyond sin theta
		d = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}; send_pair(d);
		d = {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001}; send_pair(d);
		repeat (8) send_pair(unit_pair());
		drain();

		// Extremes: full reflectance with out-of-range roughness.
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 16'hFFFF);
		repeat (6) send_pair(unit_pair());
		run_random(300);
		drain();

		set_regs(16'h0000, 16'h0000, 16'h0000, 17'h00000, 16'h0000);
		run_random(150);
		drain();

		// Long receiver hold-off while words keep coming, so the block fills up.
		set_regs(16'($urandom), 16'($urandom), 16'($urandom), 17'h10000, 16'h8000);
		hold_rx = 1;
		for (int k = 0; k < 200; k++) send_pair(unit_pair(), 1);
		run_random(300);
		drain();

		repeat (3) begin
			set_regs(16'($urandom), 16'($urandom), 16'($urandom),
				17'($urandom_range(0, 17'h1FFFF)), 16'($urandom));
			run_random(225);
			drain();
		end

		stim_done = 1;
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
